### rtl/core/mm64_pkg.sv
// Shared constants, types and helpers for the MurmurHash64A stream hasher.
package mm64_pkg;

   // Multiplier constant and its 32-bit halves
   localparam logic [63:0] MUL_CONST = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MUL_LO    = MUL_CONST[31:0];
   localparam logic [31:0] MUL_HI    = MUL_CONST[63:32];
   localparam int          SHIFT_R   = 47;

   // Controller states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_SEED  = 8'b0000_0100,
      ST_MIXA  = 8'b0000_1000,
      ST_MIXB  = 8'b0001_0000,
      ST_HMUL  = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   // Source of the next multiplier operand
   typedef enum logic [2:0] {
      OPND_LEN,
      OPND_WORD,
      OPND_KMIX,
      OPND_HMIX,
      OPND_TAIL,
      OPND_FIN
   } opnd_sel_type;

   // Next value of the running hash
   typedef enum logic [1:0] {
      HSEL_HOLD,
      HSEL_SEED,
      HSEL_PROD
   } hsel_type;

   typedef struct packed {
      logic         capture;
      logic         mul_start;
      opnd_sel_type opnd_sel;
      hsel_type     h_sel;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic full;
      logic partial;
      logic mul_done;
      logic out_free;
   } dp_stat_type;

   // x ^ (x >> 47)
   function automatic logic [63:0] mix_shift(input logic [63:0] x);
      return x ^ (x >> SHIFT_R);
   endfunction

endpackage

### rtl/core/mm64_mul.sv
// Iterative 64-bit multiply by the hash constant, modulo 2^64, on one 32x32 multiplier.
module mm64_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] product
);
   import mm64_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] opnd_ff, opnd_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_x, mul_y;
   logic [63:0] pp;

   // Partial product: aL*mL, then aL*mH and aH*mL into the upper half
   assign mul_x = step_ff[2] ? opnd_ff[63:32] : opnd_ff[31:0];
   assign mul_y = step_ff[1] ? MUL_HI : MUL_LO;
   assign pp    = mul_x * mul_y;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'b001;
         opnd_in = operand;
      end else if (busy_ff) begin
         acc_in  = step_ff[0] ? pp : acc_ff + {pp[31:0], 32'b0};
         step_in = {step_ff[1:0], 1'b0};
         if (step_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'b000;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### rtl/core/mm64_dp.sv
// Datapath: input capture, seed and running hash, operand selection, multiplier, result register.
module mm64_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mm64_pkg::dp_cmd_type cmd,
   output mm64_pkg::dp_stat_type stat,
   input  logic [63:0]          in_word,
   input  logic [3:0]           in_valid_bytes,
   input  logic                 in_first,
   input  logic                 in_last,
   input  logic [31:0]          in_total_length,
   input  logic                 seed_we,
   input  logic [63:0]          seed_wdata,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [63:0]          rsp_tdata
);
   import mm64_pkg::*;

   logic [63:0] seed_ff;
   logic [63:0] h_ff, h_in;
   logic [63:0] word_ff;
   logic [31:0] len_ff;
   logic [2:0]  tail_ff;
   logic        first_ff, last_ff, full_ff, partial_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff;
   logic [63:0] tail_mask;
   logic [63:0] opnd;
   logic [63:0] mul_prod;
   logic        mul_done;

   mm64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .operand (opnd),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Keep the low tail bytes of a partial word
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         tail_mask[8*i +: 8] = (3'(i) < tail_ff) ? 8'hFF : 8'h00;
      end
   end

   // Next running hash
   always_comb begin
      unique case (cmd.h_sel)
         HSEL_HOLD: h_in = h_ff;
         HSEL_SEED: h_in = seed_ff ^ mul_prod;
         HSEL_PROD: h_in = mul_prod;
         default:   h_in = h_ff;
      endcase
   end

   // Multiplier operand
   always_comb begin
      unique case (cmd.opnd_sel)
         OPND_LEN:  opnd = {32'b0, len_ff};
         OPND_WORD: opnd = word_ff;
         OPND_KMIX: opnd = mix_shift(mul_prod);
         OPND_HMIX: opnd = h_ff ^ mul_prod;
         OPND_TAIL: opnd = h_in ^ (word_ff & tail_mask);
         OPND_FIN:  opnd = mix_shift(h_in);
         default:   opnd = word_ff;
      endcase
   end

   // Result register: loads while empty or while its beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (seed_we) begin
            seed_ff <= seed_wdata;
         end
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         word_ff    <= in_word;
         len_ff     <= in_total_length;
         tail_ff    <= in_valid_bytes[2:0];
         first_ff   <= in_first;
         last_ff    <= in_last;
         full_ff    <= in_valid_bytes[3];
         partial_ff <= !in_valid_bytes[3] && (in_valid_bytes[2:0] != 3'd0);
      end
      if (cmd.out_load) begin
         rsp_data_ff <= mix_shift(mul_prod);
      end
   end

   assign stat.first    = first_ff;
   assign stat.last     = last_ff;
   assign stat.full     = full_ff;
   assign stat.partial  = partial_ff;
   assign stat.mul_done = mul_done;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/mm64_ctrl.sv
// Controller: sequences seeding, word mixing and finalization over the shared multiplier.
module mm64_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mm64_pkg::dp_stat_type stat,
   output mm64_pkg::dp_cmd_type  cmd
);
   import mm64_pkg::*;

   state_type state_ff, state_in;
   logic      word_step;

   always_comb begin
      cmd          = '0;
      cmd.opnd_sel = OPND_WORD;
      cmd.h_sel    = HSEL_HOLD;
      state_in     = state_ff;
      word_step    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            if (stat.first) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_LEN;
               state_in      = ST_SEED;
            end else begin
               word_step = 1'b1;
            end
         end
         ST_SEED: begin
            if (stat.mul_done) begin
               cmd.h_sel = HSEL_SEED;
               word_step = 1'b1;
            end
         end
         ST_MIXA: begin
            if (stat.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_KMIX;
               state_in      = ST_MIXB;
            end
         end
         ST_MIXB: begin
            if (stat.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_HMIX;
               state_in      = ST_HMUL;
            end
         end
         ST_HMUL: begin
            if (stat.mul_done) begin
               cmd.h_sel = HSEL_PROD;
               if (stat.last) begin
                  cmd.mul_start = 1'b1;
                  cmd.opnd_sel  = OPND_FIN;
                  state_in      = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN: begin
            if (stat.mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Word phase, once the running hash is current
      if (word_step) begin
         priority if (stat.full) begin
            cmd.mul_start = 1'b1;
            cmd.opnd_sel  = OPND_WORD;
            state_in      = ST_MIXA;
         end else if (stat.partial) begin
            cmd.mul_start = 1'b1;
            cmd.opnd_sel  = OPND_TAIL;
            state_in      = ST_HMUL;
         end else if (stat.last) begin
            cmd.mul_start = 1'b1;
            cmd.opnd_sel  = OPND_FIN;
            state_in      = ST_FIN;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### rtl/core/murmur64_stream_hash.sv
// Top level of the MurmurHash64A stream hasher.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: word, valid_bytes, total_length;
//          |     |                        | tuser: first; tlast: last
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: digest
//  csr     | in  | csr_valid/csr_ready    | csr_wdata: seed
//
//  Every 64-bit multiply by the hash constant runs on one shared 32x32 multiplier. An
//  item needs 0 to 5 multiplies: one to seed on first, three for a full word or one
//  for a partial word, one to finalize on last; on last the result register is then
//  loaded.
//  Reset is synchronous; it clears the seed and the running hash to zero.
//  A waiting result does not block the next beat; only the next digest waits for it.
module murmur64_stream_hash (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // word[63:0], valid_bytes[67:64], total_length[99:68], zero
   input  logic [0:0]   req_tuser,   // first[0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // digest[63:0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_wdata
);
   import mm64_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   mm64_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mm64_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_word         (req_tdata[63:0]),
      .in_valid_bytes  (req_tdata[67:64]),
      .in_first        (req_tuser[0]),
      .in_last         (req_tlast),
      .in_total_length (req_tdata[99:68]),
      .seed_we         (csr_valid && csr_ready),
      .seed_wdata      (csr_wdata),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

### rtl/core/mm64_check.sv
// Port-level checks for the MurmurHash64A stream hasher, bound to the top level.
module mm64_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);

   // A stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // A stalled result beat keeps its digest
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp digest changed while stalled");

   // An accepted beat keeps the hasher busy for at least the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted again right after a beat");

   // A new digest appears only as the hasher goes back to taking input
   a_rsp_rise_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("digest offered while an item is still in work");

endmodule

bind murmur64_stream_hash mm64_check u_check (.*);
